// ===== rtl/core/point_segment_distance_top_macros.svh =====
// ----------------------------------------------------------------------------
// point_segment_distance_top_macros
// assertion macros for the point to segment distance rtl
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_TOP_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_TOP_MACROS_SVH

// same-cycle implication
`define PSD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// types and widths for the point to segment distance pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psd_pkg;

   localparam int CB  = 24;
   localparam int FB  = 16;
   localparam int DW  = CB + 1;
   localparam int PW  = 2 * CB + 2;
   localparam int LW  = 2 * CB + 2;
   localparam int SW  = LW + 1;
   localparam int TW  = FB + 1;
   localparam int MW  = TW + 1 + DW;
   localparam int EW  = CB + 2;
   localparam int QW  = 2 * EW;
   localparam int RMW = EW + 2;

   localparam logic [TW-1:0] ONE_FRAC = TW'(1) << FB;
   localparam logic [CB:0]   DIST_MAX = '1;

   typedef struct packed {
      logic signed [CB-1:0] point_x;
      logic signed [CB-1:0] point_y;
      logic signed [CB-1:0] seg_start_x;
      logic signed [CB-1:0] seg_start_y;
      logic signed [CB-1:0] seg_end_x;
      logic signed [CB-1:0] seg_end_y;
   } req_type;

   typedef struct packed {
      logic [CB:0]   distance;
      logic [FB:0]   proj_fraction;
      logic          degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [CB-1:0] px;
      logic signed [CB-1:0] py;
      logic signed [CB-1:0] ax;
      logic signed [CB-1:0] ay;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
   } geo_type;

   typedef struct packed {
      geo_type          geo;
      logic [LW-1:0]    len2;
      logic [LW-1:0]    r;
      logic [FB-1:0]    q;
      logic             low;
      logic             high;
      logic             degen;
   } div_type;

   typedef struct packed {
      logic [TW-1:0] t;
      logic          degen;
   } side_type;

endpackage

// ===== rtl/core/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// differences, products and sums: squared length and dot product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_front import psd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  req_type              in_req,
   output logic                 out_valid,
   output geo_type              out_geo,
   output logic [LW-1:0]        out_len2,
   output logic signed [SW-1:0] out_dot
);

   logic                 v1_ff, v2_ff, v3_ff;
   geo_type              geo1_ff, geo2_ff, geo3_ff, geo1_in;
   logic signed [DW-1:0] rx1_ff, ry1_ff, rx1_in, ry1_in;
   logic signed [PW-1:0] xx2_ff, yy2_ff, xd2_ff, yd2_ff;
   logic [LW-1:0]        len2_ff, len2_in;
   logic signed [SW-1:0] dot_ff, dot_in;

   always_comb begin
      geo1_in.px = in_req.point_x;
      geo1_in.py = in_req.point_y;
      geo1_in.ax = in_req.seg_start_x;
      geo1_in.ay = in_req.seg_start_y;
      geo1_in.dx = DW'(in_req.seg_end_x) - DW'(in_req.seg_start_x);
      geo1_in.dy = DW'(in_req.seg_end_y) - DW'(in_req.seg_start_y);
      rx1_in     = DW'(in_req.point_x) - DW'(in_req.seg_start_x);
      ry1_in     = DW'(in_req.point_y) - DW'(in_req.seg_start_y);
      len2_in    = $unsigned(xx2_ff + yy2_ff);
      dot_in     = SW'(xd2_ff) + SW'(yd2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         geo1_ff <= geo1_in;
         rx1_ff  <= rx1_in;
         ry1_ff  <= ry1_in;
         geo2_ff <= geo1_ff;
         xx2_ff  <= PW'(geo1_ff.dx * geo1_ff.dx);
         yy2_ff  <= PW'(geo1_ff.dy * geo1_ff.dy);
         xd2_ff  <= PW'(rx1_ff * geo1_ff.dx);
         yd2_ff  <= PW'(ry1_ff * geo1_ff.dy);
         geo3_ff <= geo2_ff;
         len2_ff <= len2_in;
         dot_ff  <= dot_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_geo   = geo3_ff;
   assign out_len2  = len2_ff;
   assign out_dot   = dot_ff;

endmodule

// ===== rtl/core/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// clamp classification and restoring divide, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_div import psd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  geo_type              in_geo,
   input  logic [LW-1:0]        in_len2,
   input  logic signed [SW-1:0] in_dot,
   output logic                 out_valid,
   output div_type              out_div
);

   logic    cv_ff;
   div_type cls_ff, cls_in;
   logic    v_ff  [FB];
   div_type st_ff [FB];
   div_type st_in [FB];

   always_comb begin
      cls_in.geo   = in_geo;
      cls_in.len2  = in_len2;
      cls_in.q     = '0;
      cls_in.degen = (in_len2 == '0);
      cls_in.low   = in_dot[SW-1] || (in_dot == '0);
      cls_in.high  = !cls_in.low && (in_dot[LW-1:0] >= in_len2);
      cls_in.r     = (cls_in.degen || cls_in.low || cls_in.high) ? '0 : in_dot[LW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
      end else if (advance) begin
         cv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cls_ff <= cls_in;
      end
   end

   for (genvar k = 0; k < FB; k++) begin : g_step
      div_type     src;
      logic        src_v;
      logic [LW:0] r2;
      logic        ge;

      if (k == 0) begin : g_first
         assign src   = cls_ff;
         assign src_v = cv_ff;
      end else begin : g_rest
         assign src   = st_ff[k-1];
         assign src_v = v_ff[k-1];
      end

      always_comb begin
         r2       = {src.r, 1'b0};
         ge       = (r2 >= {1'b0, src.len2});
         st_in[k] = src;
         st_in[k].r = ge ? LW'(r2 - {1'b0, src.len2}) : r2[LW-1:0];
         st_in[k].q = {src.q[FB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid = v_ff[FB-1];
   assign out_div   = st_ff[FB-1];

endmodule

// ===== rtl/core/psd_proj.sv =====
// ----------------------------------------------------------------------------
// psd_proj
// projected point, offset to the query point and squared distance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_proj import psd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  div_type       in_div,
   output logic          out_valid,
   output logic [QW-1:0] out_d2,
   output side_type      out_side
);

   logic                 va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   geo_type              geoa_ff, geob_ff;
   side_type             sa_ff, sb_ff, sc_ff, sd_ff, se_ff, sa_in;
   logic signed [MW-1:0] mx_ff, my_ff;
   logic signed [MW-1:0] sx, sy;
   logic signed [EW-1:0] ex_ff, ey_ff, ex_in, ey_in;
   logic [QW-1:0]        qx_ff, qy_ff, d2_ff;

   always_comb begin
      sa_in.degen = in_div.degen;
      if (in_div.degen || in_div.low) begin
         sa_in.t = '0;
      end else if (in_div.high) begin
         sa_in.t = ONE_FRAC;
      end else begin
         sa_in.t = {1'b0, in_div.q};
      end
      sx    = mx_ff >>> FB;
      sy    = my_ff >>> FB;
      ex_in = EW'(geob_ff.px) - EW'(geob_ff.ax) - EW'(sx);
      ey_in = EW'(geob_ff.py) - EW'(geob_ff.ay) - EW'(sy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         geoa_ff <= in_div.geo;
         sa_ff   <= sa_in;
         geob_ff <= geoa_ff;
         sb_ff   <= sa_ff;
         mx_ff   <= MW'($signed({1'b0, sa_ff.t}) * geoa_ff.dx);
         my_ff   <= MW'($signed({1'b0, sa_ff.t}) * geoa_ff.dy);
         sc_ff   <= sb_ff;
         ex_ff   <= ex_in;
         ey_ff   <= ey_in;
         sd_ff   <= sc_ff;
         qx_ff   <= $unsigned(QW'(ex_ff * ex_ff));
         qy_ff   <= $unsigned(QW'(ey_ff * ey_ff));
         se_ff   <= sd_ff;
         d2_ff   <= qx_ff + qy_ff;
      end
   end

   assign out_valid = ve_ff;
   assign out_d2    = d2_ff;
   assign out_side  = se_ff;

endmodule

// ===== rtl/core/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt
// pipelined floor integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_sqrt import psd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  logic [QW-1:0]  in_d2,
   input  side_type       in_side,
   output logic           out_valid,
   output logic [EW-1:0]  out_root,
   output side_type       out_side
);

   logic           v_ff    [EW];
   logic [RMW-1:0] rem_ff  [EW];
   logic [EW-1:0]  root_ff [EW];
   logic [QW-1:0]  rad_ff  [EW];
   side_type       side_ff [EW];

   for (genvar k = 0; k < EW; k++) begin : g_step
      logic           src_v;
      logic [RMW-1:0] src_rem;
      logic [EW-1:0]  src_root;
      logic [QW-1:0]  src_rad;
      side_type       src_side;
      logic [RMW-1:0] rem2, trial, rem_in;
      logic [EW-1:0]  root_in;
      logic           ge;

      if (k == 0) begin : g_first
         assign src_v    = in_valid;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_rad  = in_d2;
         assign src_side = in_side;
      end else begin : g_rest
         assign src_v    = v_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_rad  = rad_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      always_comb begin
         rem2    = {src_rem[RMW-3:0], src_rad[QW-1 -: 2]};
         trial   = {src_root, 2'b01};
         ge      = (rem2 >= trial);
         rem_in  = ge ? (rem2 - trial) : rem2;
         root_in = {src_root[EW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= src_rad << 2;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = v_ff[EW-1];
   assign out_root  = root_ff[EW-1];
   assign out_side  = side_ff[EW-1];

endmodule

// ===== rtl/core/point_segment_distance_top.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_top
// distance from a point to a segment, with the clamped projection parameter
// ----------------------------------------------------------------------------
// Takes one beat per clock while req_stall is low and gives one result beat
// per request, in order, after differences, products and sums, clamp
// classification, 16 restoring divide stages (one per fraction bit), the
// projected point and squared distance, 26 square root stages (one per root
// bit) and the output register. A result stall while rsp_valid is high
// freezes the whole pipeline and is passed back as req_stall in the same cycle.
`timescale 1ns / 1ps
`include "point_segment_distance_top_macros.svh"

module point_segment_distance_top import psd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                 advance;
   logic                 fr_valid, dv_valid, pj_valid, sq_valid;
   geo_type              fr_geo;
   logic [LW-1:0]        fr_len2;
   logic signed [SW-1:0] fr_dot;
   div_type              dv_div;
   logic [QW-1:0]        pj_d2;
   side_type             pj_side, sq_side;
   logic [EW-1:0]        sq_root;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .out_valid (fr_valid),
      .out_geo   (fr_geo),
      .out_len2  (fr_len2),
      .out_dot   (fr_dot)
   );

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fr_valid),
      .in_geo    (fr_geo),
      .in_len2   (fr_len2),
      .in_dot    (fr_dot),
      .out_valid (dv_valid),
      .out_div   (dv_div)
   );

   psd_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dv_valid),
      .in_div    (dv_div),
      .out_valid (pj_valid),
      .out_d2    (pj_d2),
      .out_side  (pj_side)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pj_valid),
      .in_d2     (pj_d2),
      .in_side   (pj_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      rsp_in.distance      = (sq_root > EW'(DIST_MAX)) ? DIST_MAX : sq_root[CB:0];
      rsp_in.proj_fraction = sq_side.t;
      rsp_in.degenerate    = sq_side.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PSD_ASSERT_IMPL(a_degen_zero_t, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.proj_fraction == '0)
   `PSD_ASSERT_IMPL(a_t_in_range, clock, reset, rsp_valid, rsp_data.proj_fraction <= ONE_FRAC)
   `PSD_ASSERT_NEXT(a_stall_holds_out, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule
